/* hw/rtl/dshl_pkg.sv */
// types and constants shared by the decimating sensor history log
package dshl_pkg;

  localparam int unsigned NumMetrics = 3;
  localparam int unsigned WordW      = 32;
  localparam int unsigned TimeW      = 32;
  localparam int unsigned BaseW      = 27;
  localparam int unsigned RateW      = 11;
  localparam int unsigned MetricW    = 2;
  localparam int unsigned LimitW     = 8;
  localparam int unsigned EntryW     = 6;
  localparam int unsigned CfgIdxW    = 1;
  localparam int unsigned CfgDataW   = BaseW;
  localparam int unsigned ProdW      = BaseW + RateW;

  localparam logic [RateW-1:0]   RateReset   = RateW'(1);
  localparam logic [RateW-1:0]   RateCeiling = RateW'(1024);
  localparam logic [RateW-1:0]   MaxReset    = RateW'(8);
  localparam logic [BaseW-1:0]   BaseReset   = BaseW'(60000);

  localparam logic [CfgIdxW-1:0] CfgBaseInterval = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgMaxMult      = 1'd1;

  localparam logic [MetricW-1:0] MetricTemp     = 2'd0;
  localparam logic [MetricW-1:0] MetricHumidity = 2'd1;
  localparam logic [MetricW-1:0] MetricPressure = 2'd2;
  localparam logic [MetricW-1:0] MetricNone     = 2'd3;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_READ   = 1'b1
  } opcode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DEC,
    ST_APP,
    ST_MUL,
    ST_ADD,
    ST_RD_ISSUE,
    ST_RD_WAIT,
    ST_EMPTY
  } state_e;

  typedef struct packed {
    logic               opcode;
    logic [TimeW-1:0]   time_now;
    logic               sample_valid;
    logic               temp_present;
    logic               humidity_present;
    logic               pressure_present;
    logic [WordW-1:0]   temp_word;
    logic [WordW-1:0]   humidity_word;
    logic [WordW-1:0]   pressure_word;
    logic [MetricW-1:0] read_metric;
    logic [LimitW-1:0]  read_limit;
  } in_beat_t;

  typedef struct packed {
    logic [WordW-1:0]  out_word;
    logic [EntryW-1:0] entry_index;
    logic              last;
    logic              empty_res;
  } out_beat_t;

endpackage

/* hw/rtl/dshl_in_if.sv */
// valid/ready channel carrying sample and read requests
interface dshl_in_if import dshl_pkg::*; ();
  logic     valid;
  logic     ready;
  in_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/dshl_out_if.sv */
// valid/ready channel carrying history words
interface dshl_out_if import dshl_pkg::*; ();
  logic      valid;
  logic      ready;
  out_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/decimating_sensor_history_log_core.sv */
// decimating sensor history log: three circular histories in one memory
//
// in_i takes one request per beat. A sample request (opcode 0) is dropped
// if time_now is before the due time. An invalid sample (sample_valid 0)
// only sets the new due time. Otherwise the block decimates all histories
// if needed, appends the present words and sets the new due time; it
// produces no beat on out_o. During decimation the single memory port pair
// walks one entry per cycle. A read request (opcode 1) streams up to
// read_limit words of one history, oldest first, last set on the final
// beat; an empty read gives one beat with empty_res set. Each word is a
// memory read, then a load of the output register. The output register
// lets the block accept the next request while the last beat waits; when
// out_o stalls, the block holds at that word. in_i.ready is high only
// between requests. Reset clears counts, pointers, due time (0), rate
// factor (1) and registers (60000, 8); memory contents are not cleared.
// cfg_we_i writes register cfg_idx_i; the user must do so only while
// idle, as the block itself does not enforce it.
module decimating_sensor_history_log_core import dshl_pkg::*; #(
  parameter int unsigned HISTORY_DEPTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  dshl_in_if.sink             in_i,
  dshl_out_if.source          out_o
);

  localparam int unsigned IdxW  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned CntW  = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned MemD  = NumMetrics * HISTORY_DEPTH;
  localparam int unsigned AddrW = $clog2(MemD);
  localparam logic [CntW-1:0] Depth = CntW'(HISTORY_DEPTH);

  function automatic logic [IdxW-1:0] slot(logic [IdxW-1:0] head, logic [CntW-1:0] off);
    logic [IdxW:0] s;
    s = {1'b0, head} + (IdxW+1)'(off);
    if (s >= (IdxW+1)'(HISTORY_DEPTH)) begin
      s = s - (IdxW+1)'(HISTORY_DEPTH);
    end
    return s[IdxW-1:0];
  endfunction

  function automatic logic [AddrW-1:0] phys(logic [MetricW-1:0] m, logic [IdxW-1:0] s);
    return AddrW'(m) * AddrW'(HISTORY_DEPTH) + AddrW'(s);
  endfunction

  state_e                   state_q, state_d;
  logic [CntW-1:0]          cnt_q [NumMetrics];
  logic [CntW-1:0]          cnt_d [NumMetrics];
  logic [IdxW-1:0]          head_q [NumMetrics];
  logic [IdxW-1:0]          head_d [NumMetrics];
  logic [TimeW-1:0]         due_q, due_d;
  logic [RateW-1:0]         rate_q, rate_d;
  logic [BaseW-1:0]         base_q;
  logic [RateW-1:0]         max_q;
  logic [CntW-1:0]          j_q, j_d;
  logic [MetricW-1:0]       m_q, m_d;
  logic [CntW-1:0]          nrd_q, nrd_d;
  logic [TimeW-1:0]         now_q;
  logic [NumMetrics-1:0]    pres_q;
  logic [WordW-1:0]         word_q [NumMetrics];
  logic [TimeW-1:0]         prod_q, prod_d;
  logic [ProdW-1:0]         prod_full;

  logic [WordW-1:0]         mem_q [MemD];
  logic [WordW-1:0]         rdata_q;
  logic                     rd_en, wr_en;
  logic [AddrW-1:0]         rd_addr, wr_addr;

  logic                     ov_q, ov_d;
  out_beat_t                obeat_q, obeat_d;
  logic                     load, out_free, latch;

  logic [CntW-1:0]          cur_cnt, rd_cnt, half;
  logic [IdxW-1:0]          cur_head;
  logic                     cur_pres, full;
  logic [WordW-1:0]         cur_word;

  always_comb begin
    unique case (m_q)
      MetricTemp: begin
        cur_cnt  = cnt_q[0];
        cur_head = head_q[0];
        cur_pres = pres_q[0];
        cur_word = word_q[0];
      end
      MetricHumidity: begin
        cur_cnt  = cnt_q[1];
        cur_head = head_q[1];
        cur_pres = pres_q[1];
        cur_word = word_q[1];
      end
      MetricPressure: begin
        cur_cnt  = cnt_q[2];
        cur_head = head_q[2];
        cur_pres = pres_q[2];
        cur_word = word_q[2];
      end
      default: begin
        cur_cnt  = '0;
        cur_head = '0;
        cur_pres = 1'b0;
        cur_word = '0;
      end
    endcase
  end

  always_comb begin
    unique case (in_i.data.read_metric)
      MetricTemp:     rd_cnt = cnt_q[0];
      MetricHumidity: rd_cnt = cnt_q[1];
      MetricPressure: rd_cnt = cnt_q[2];
      default:        rd_cnt = '0;
    endcase
  end

  assign half = CntW'(({1'b0, cur_cnt} + (CntW+1)'(1)) >> 1);
  assign full = (in_i.data.temp_present     && cnt_q[0] >= Depth) ||
                (in_i.data.humidity_present && cnt_q[1] >= Depth) ||
                (in_i.data.pressure_present && cnt_q[2] >= Depth);
  assign prod_full = ProdW'(base_q) * ProdW'(rate_q);
  assign out_free  = !ov_q || out_o.ready;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    head_d  = head_q;
    due_d   = due_q;
    rate_d  = rate_q;
    j_d     = j_q;
    m_d     = m_q;
    nrd_d   = nrd_q;
    prod_d  = prod_q;
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    load    = 1'b0;
    latch   = 1'b0;
    obeat_d = obeat_q;
    in_i.ready = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          latch = 1'b1;
          j_d   = '0;
          if (in_i.data.opcode == OP_SAMPLE) begin
            if (in_i.data.time_now < due_q) begin
              state_d = ST_IDLE;
            end else if (!in_i.data.sample_valid) begin
              state_d = ST_MUL;
            end else if (full && rate_q < max_q) begin
              state_d = ST_DEC;
              m_d     = MetricTemp;
              if (rate_q < RateCeiling) begin
                rate_d = rate_q << 1;
              end
            end else begin
              state_d = ST_APP;
              m_d     = MetricTemp;
            end
          end else begin
            m_d = in_i.data.read_metric;
            if (in_i.data.read_metric == MetricNone || in_i.data.read_limit == '0 ||
                rd_cnt == '0) begin
              state_d = ST_EMPTY;
            end else begin
              nrd_d   = (LimitW'(rd_cnt) < in_i.data.read_limit) ? rd_cnt
                                                                 : CntW'(in_i.data.read_limit);
              state_d = ST_RD_ISSUE;
            end
          end
        end
      end

      // even entry 2j is read while entry j-1 gets the word read last cycle
      ST_DEC: begin
        if (j_q < half) begin
          rd_en   = 1'b1;
          rd_addr = phys(m_q, slot(cur_head, CntW'({j_q, 1'b0})));
        end
        if (j_q != '0) begin
          wr_en   = 1'b1;
          wr_addr = phys(m_q, slot(cur_head, j_q - CntW'(1)));
        end
        if (j_q == half) begin
          cnt_d[m_q] = half;
          j_d        = '0;
          if (m_q == MetricPressure) begin
            state_d = ST_APP;
            m_d     = MetricTemp;
          end else begin
            m_d = m_q + MetricW'(1);
          end
        end else begin
          j_d = j_q + CntW'(1);
        end
      end

      ST_APP: begin
        if (cur_pres) begin
          wr_en = 1'b1;
          if (cur_cnt >= Depth) begin
            wr_addr     = phys(m_q, cur_head);
            head_d[m_q] = slot(cur_head, CntW'(1));
          end else begin
            wr_addr    = phys(m_q, slot(cur_head, cur_cnt));
            cnt_d[m_q] = cur_cnt + CntW'(1);
          end
        end
        if (m_q == MetricPressure) begin
          state_d = ST_MUL;
        end else begin
          m_d = m_q + MetricW'(1);
        end
      end

      ST_MUL: begin
        prod_d  = prod_full[TimeW-1:0];
        state_d = ST_ADD;
      end

      ST_ADD: begin
        due_d   = now_q + prod_q;
        state_d = ST_IDLE;
      end

      ST_RD_ISSUE: begin
        rd_en   = 1'b1;
        rd_addr = phys(m_q, slot(cur_head, j_q));
        state_d = ST_RD_WAIT;
      end

      ST_RD_WAIT: begin
        if (out_free) begin
          load                = 1'b1;
          obeat_d.out_word    = rdata_q;
          obeat_d.entry_index = EntryW'(j_q);
          obeat_d.last        = (j_q + CntW'(1) == nrd_q);
          obeat_d.empty_res   = 1'b0;
          if (j_q + CntW'(1) == nrd_q) begin
            state_d = ST_IDLE;
          end else begin
            j_d     = j_q + CntW'(1);
            state_d = ST_RD_ISSUE;
          end
        end
      end

      ST_EMPTY: begin
        if (out_free) begin
          load                = 1'b1;
          obeat_d.out_word    = '0;
          obeat_d.entry_index = '0;
          obeat_d.last        = 1'b1;
          obeat_d.empty_res   = 1'b1;
          state_d             = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase

    if (load) begin
      ov_d = 1'b1;
    end else if (out_o.ready) begin
      ov_d = 1'b0;
    end else begin
      ov_d = ov_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      due_q   <= '0;
      rate_q  <= RateReset;
      base_q  <= BaseReset;
      max_q   <= MaxReset;
      ov_q    <= 1'b0;
      j_q     <= '0;
      m_q     <= MetricTemp;
      for (int k = 0; k < NumMetrics; k++) begin
        cnt_q[k]  <= '0;
        head_q[k] <= '0;
      end
    end else begin
      state_q <= state_d;
      due_q   <= due_d;
      rate_q  <= rate_d;
      ov_q    <= ov_d;
      j_q     <= j_d;
      m_q     <= m_d;
      cnt_q   <= cnt_d;
      head_q  <= head_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgBaseInterval) begin
          base_q <= cfg_data_i;
        end else if (cfg_idx_i == CfgMaxMult) begin
          max_q <= cfg_data_i[RateW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    nrd_q   <= nrd_d;
    prod_q  <= prod_d;
    obeat_q <= obeat_d;
    if (latch) begin
      now_q     <= in_i.data.time_now;
      pres_q    <= {in_i.data.pressure_present, in_i.data.humidity_present,
                    in_i.data.temp_present};
      word_q[0] <= in_i.data.temp_word;
      word_q[1] <= in_i.data.humidity_word;
      word_q[2] <= in_i.data.pressure_word;
    end
  end

  // history memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= (state_q == ST_APP) ? cur_word : rdata_q;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  assign out_o.valid = ov_q;
  assign out_o.data  = obeat_q;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q[0] <= Depth && cnt_q[1] <= Depth && cnt_q[2] <= Depth)
    else $error("history count above depth");

  a_rate_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(rate_q))
    else $error("rate factor not a power of two");

  a_no_port_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rd_en && wr_en && rd_addr == wr_addr && state_q == ST_DEC && j_q > CntW'(1)))
    else $error("decimation read and write hit the same entry");

  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && obeat_q.empty_res |-> obeat_q.last)
    else $error("empty beat without last");

  a_rate_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rate_q != $past(rate_q) |-> $past(state_q) == ST_IDLE && state_q == ST_DEC)
    else $error("rate factor changed outside decimation start");
`endif

endmodule

/* bench/decimating_sensor_history_log_core_test.sv */
// self-checking testbench for the decimating sensor history log core
module decimating_sensor_history_log_core_test import dshl_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HistDepth = 32;

  typedef enum logic [1:0] {
    AT_GIVEN,
    AT_DUE,
    AT_EARLY
  } stamp_e;

  typedef struct {
    in_beat_t beat;
    stamp_e   stamp;
    bit       drain_first;
  } request_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  dshl_in_if  in_bus ();
  dshl_out_if out_bus ();

  decimating_sensor_history_log_core #(
    .HISTORY_DEPTH(HistDepth)
  ) u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .in_i      (in_bus),
    .out_o     (out_bus)
  );

  always #10 clk_i = ~clk_i;

  // predicted block state
  logic [WordW-1:0] hist [NumMetrics][HistDepth];
  int unsigned      hist_count [NumMetrics] = '{default: 0};
  logic [TimeW-1:0] due_ms = '0;
  logic [RateW-1:0] rate = RateReset;
  logic [BaseW-1:0] base_ms;
  logic [RateW-1:0] max_mult;

  request_t    request_queue [$];
  out_beat_t   awaited [$];
  int unsigned mismatches = 0;

  bit          in_taken  = 1'b0;
  bit          out_taken = 1'b0;
  int unsigned send_gap  = 0;
  int unsigned send_run  = 0;
  bit          send_calm = 1'b0;
  int unsigned recv_wait = 0;
  int unsigned recv_run  = 0;
  bit          recv_calm = 1'b0;

  function automatic void push_due(logic [TimeW-1:0] now);
    logic [63:0] span;
    span   = 64'(base_ms) * 64'(rate);
    due_ms = TimeW'(64'(now) + span);
  endfunction

  function automatic void log_sample(in_beat_t b);
    logic [NumMetrics-1:0] present;
    logic [WordW-1:0]      word [NumMetrics];
    bit                    full;
    int unsigned           w;
    present = {b.pressure_present, b.humidity_present, b.temp_present};
    word[MetricTemp]     = b.temp_word;
    word[MetricHumidity] = b.humidity_word;
    word[MetricPressure] = b.pressure_word;
    if (b.time_now < due_ms) return;
    if (!b.sample_valid) begin
      push_due(b.time_now);
      return;
    end
    full = 1'b0;
    for (int m = 0; m < NumMetrics; m++) begin
      if (present[m] && hist_count[m] >= HistDepth) full = 1'b1;
    end
    if (full && rate < max_mult) begin
      for (int m = 0; m < NumMetrics; m++) begin
        if (hist_count[m] >= 2) begin
          w = 0;
          for (int unsigned r = 0; r < hist_count[m]; r += 2) begin
            hist[m][w] = hist[m][r];
            w++;
          end
          hist_count[m] = w;
        end
      end
      if (rate < RateCeiling) rate = rate << 1;
    end
    for (int m = 0; m < NumMetrics; m++) begin
      if (present[m]) begin
        if (hist_count[m] >= HistDepth) begin
          for (int k = 0; k < HistDepth - 1; k++) hist[m][k] = hist[m][k+1];
          hist_count[m] = HistDepth - 1;
        end
        hist[m][hist_count[m]] = word[m];
        hist_count[m]++;
      end
    end
    push_due(b.time_now);
  endfunction

  function automatic void stream_history(in_beat_t b);
    out_beat_t   o;
    int unsigned n;
    bit          blank;
    blank = (b.read_metric == MetricNone) || (b.read_limit == 0);
    if (!blank) blank = (hist_count[b.read_metric] == 0);
    if (blank) begin
      o.out_word    = '0;
      o.entry_index = '0;
      o.last        = 1'b1;
      o.empty_res   = 1'b1;
      awaited.push_back(o);
      return;
    end
    n = hist_count[b.read_metric];
    if (32'(b.read_limit) < n) n = 32'(b.read_limit);
    for (int unsigned i = 0; i < n; i++) begin
      o.out_word    = hist[b.read_metric][i];
      o.entry_index = EntryW'(i);
      o.last        = (i + 1 == n);
      o.empty_res   = 1'b0;
      awaited.push_back(o);
    end
  endfunction

  function automatic void check_field(string name, logic [WordW-1:0] want,
                                      logic [WordW-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin : watch
    out_beat_t want;
    in_taken  <= rst_ni && in_bus.valid && in_bus.ready;
    out_taken <= rst_ni && out_bus.valid && out_bus.ready;
    if (rst_ni && in_bus.valid && in_bus.ready) begin
      if (in_bus.data.opcode == OP_READ) stream_history(in_bus.data);
      else log_sample(in_bus.data);
    end
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (awaited.size() == 0) begin
        $error("history beat with nothing pending: word %0h", out_bus.data.out_word);
        mismatches++;
      end else begin
        want = awaited.pop_front();
        check_field("out_word", want.out_word, out_bus.data.out_word);
        check_field("entry_index", WordW'(want.entry_index),
                    WordW'(out_bus.data.entry_index));
        check_field("last", WordW'(want.last), WordW'(out_bus.data.last));
        check_field("empty_res", WordW'(want.empty_res), WordW'(out_bus.data.empty_res));
      end
    end
  end

  always @(negedge clk_i) begin : send
    request_t         r;
    logic [TimeW-1:0] t;
    int unsigned      d;
    if (!rst_ni) begin
      in_bus.valid <= 1'b0;
      in_bus.data  <= '0;
    end else if (!in_bus.valid || in_taken) begin
      if (send_gap > 0) begin
        in_bus.valid <= 1'b0;
        send_gap     <= send_gap - 1;
      end else if (request_queue.size() > 0 &&
                   !(request_queue[0].drain_first && awaited.size() > 0)) begin
        r = request_queue.pop_front();
        t = r.beat.time_now;
        // AT_DUE and AT_EARLY sample times are set from the current due time
        if (r.stamp == AT_DUE) begin
          d = $urandom_range(0, 1000);
          t = (due_ms > 32'hFFFF_FFFF - d) ? due_ms : due_ms + d;
        end else if (r.stamp == AT_EARLY) begin
          d = $urandom_range(1, 1000);
          t = (due_ms > d) ? due_ms - d : '0;
        end
        r.beat.time_now = t;
        in_bus.data  <= r.beat;
        in_bus.valid <= 1'b1;
        if (send_run == 0) begin
          send_run  <= $urandom_range(5, 30);
          send_calm <= ($urandom_range(0, 3) == 0);
        end else begin
          send_run <= send_run - 1;
        end
        send_gap <= send_calm ? 0 : $urandom_range(0, 9);
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin : recv
    int unsigned d;
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
    end else if (out_taken) begin
      if (recv_run == 0) begin
        recv_run  <= $urandom_range(4, 40);
        recv_calm <= ($urandom_range(0, 3) == 0);
      end else begin
        recv_run <= recv_run - 1;
      end
      d = recv_calm ? 0 : $urandom_range(0, 9);
      out_bus.ready <= (d == 0);
      recv_wait     <= (d == 0) ? 0 : d - 1;
    end else if (recv_wait > 0) begin
      out_bus.ready <= 1'b0;
      recv_wait     <= recv_wait - 1;
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  function automatic in_beat_t sample_beat(logic [TimeW-1:0] t, logic valid,
                                           logic [2:0] present, logic [WordW-1:0] w);
    in_beat_t b;
    b = '0;
    b.opcode           = OP_SAMPLE;
    b.time_now         = t;
    b.sample_valid     = valid;
    b.temp_present     = present[0];
    b.humidity_present = present[1];
    b.pressure_present = present[2];
    b.temp_word        = w;
    b.humidity_word    = ~w;
    b.pressure_word    = w ^ 32'h0F0F_F0F0;
    return b;
  endfunction

  task automatic queue_sample(stamp_e s, logic [TimeW-1:0] t, logic valid,
                              logic [2:0] present, logic [WordW-1:0] w);
    request_t r;
    r.beat        = sample_beat(t, valid, present, w);
    r.stamp       = s;
    r.drain_first = 1'b0;
    request_queue.push_back(r);
  endtask

  task automatic queue_read(logic [MetricW-1:0] metric, logic [LimitW-1:0] limit);
    request_t r;
    r.beat             = '0;
    r.beat.opcode      = OP_READ;
    r.beat.read_metric = metric;
    r.beat.read_limit  = limit;
    r.stamp            = AT_GIVEN;
    r.drain_first      = 1'b0;
    request_queue.push_back(r);
  endtask

  function automatic request_t random_request();
    request_t    r;
    int unsigned pick;
    r.beat.opcode           = OP_SAMPLE;
    r.beat.time_now         = $urandom;
    r.beat.sample_valid     = ($urandom_range(0, 19) != 0);
    r.beat.temp_present     = ($urandom_range(0, 9) != 0);
    r.beat.humidity_present = ($urandom_range(0, 9) != 0);
    r.beat.pressure_present = ($urandom_range(0, 9) != 0);
    r.beat.temp_word        = $urandom;
    r.beat.humidity_word    = $urandom;
    r.beat.pressure_word    = $urandom;
    r.beat.read_metric      = MetricW'($urandom_range(0, 3));
    r.beat.read_limit       = LimitW'($urandom_range(0, 255));
    r.drain_first           = ($urandom_range(0, 39) == 0);
    pick = $urandom_range(0, 99);
    if (pick < 62) begin
      r.stamp = AT_DUE;
    end else if (pick < 70) begin
      r.stamp = AT_EARLY;
    end else if (pick < 74) begin
      r.stamp = AT_GIVEN;
    end else begin
      r.stamp       = AT_GIVEN;
      r.beat.opcode = OP_READ;
      if ($urandom_range(0, 9) != 0) r.beat.read_metric = MetricW'($urandom_range(0, 2));
      pick = $urandom_range(0, 19);
      if (pick == 0) r.beat.read_limit = '0;
      else if (pick < 3) r.beat.read_limit = '1;
      else if (pick < 17) r.beat.read_limit = LimitW'($urandom_range(1, 40));
    end
    return r;
  endfunction

  task automatic settle(int unsigned tail);
    do begin
      @(posedge clk_i);
      #1;
    end while (request_queue.size() != 0 || in_bus.valid || awaited.size() != 0);
    repeat (tail) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    if (idx == CfgBaseInterval) base_ms = BaseW'(value);
    else max_mult = RateW'(value);
  endtask

  task automatic run_phase(logic [BaseW-1:0] base, logic [RateW-1:0] maxm,
                           int unsigned count);
    settle(100);
    write_reg(CfgBaseInterval, base);
    write_reg(CfgMaxMult, CfgDataW'(maxm));
    repeat (count) request_queue.push_back(random_request());
  endtask

  initial begin : main
    cfg_we        = 1'b0;
    cfg_idx       = '0;
    cfg_data      = '0;
    rst_ni        = 1'b0;
    base_ms  = BaseReset;
    max_mult = MaxReset;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    // empty histories, odd metric, due time edges, partial samples
    queue_read(MetricTemp, 8'd10);
    queue_read(MetricNone, 8'd255);
    queue_read(MetricNone, 8'd0);
    queue_sample(AT_GIVEN, '0, 1'b0, 3'b111, 32'h1234_5678);
    queue_sample(AT_EARLY, '0, 1'b1, 3'b111, 32'hDEAD_BEEF);
    queue_sample(AT_DUE, '0, 1'b1, 3'b111, 32'h0000_0000);
    queue_sample(AT_GIVEN, 32'hFFFF_FFFF, 1'b1, 3'b111, 32'hFFFF_FFFF);
    queue_sample(AT_DUE, '0, 1'b1, 3'b001, 32'hA5A5_A5A5);
    queue_sample(AT_DUE, '0, 1'b1, 3'b010, 32'h5A5A_5A5A);
    queue_sample(AT_DUE, '0, 1'b1, 3'b100, 32'h8000_0001);
    queue_sample(AT_DUE, '0, 1'b1, 3'b000, 32'h7FFF_FFFE);
    queue_sample(AT_EARLY, '0, 1'b0, 3'b111, 32'h0F0F_0F0F);
    queue_read(MetricTemp, 8'd0);
    queue_read(MetricTemp, 8'd255);
    queue_read(MetricHumidity, 8'd1);
    queue_read(MetricPressure, 8'd2);

    run_phase(BaseW'(1), RateW'(0), 45);
    run_phase(BaseW'(86400000), RateW'(2047), 70);
    run_phase('1, RateW'(1), 30);
    run_phase(BaseW'($urandom_range(1, 100000)), RateW'(1024), 80);
    run_phase(BaseW'($urandom_range(1, 5000)), RateW'(2047), 40);
    settle(200);

    if (mismatches == 0 && awaited.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : limit
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
